FILE: rtl/hhs_pkg.sv
// ----------------------------------------------------------------------------
// hhs_pkg
// Shared types and fixed field widths of the hill stamp height map.
// ----------------------------------------------------------------------------
`default_nettype none

package hhs_pkg;

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 8;
  localparam int RADIUS_W = 8;
  localparam int RESULT_W = 32;
  // square of a radius or of an offset
  localparam int SQ_W     = 2 * RADIUS_W;
  // dx*dx + dy*dy
  localparam int DIST_W   = SQ_W + 1;
  // signed peak minus distance
  localparam int AMT_W    = SQ_W + 2;
  // signed offset from the centre
  localparam int OFS_W    = RADIUS_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_STAMP = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_STAMP,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/hhs_ram.sv
// ----------------------------------------------------------------------------
// hhs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/heightmap_hill_stamp.sv
// ----------------------------------------------------------------------------
// heightmap_hill_stamp
// Square height map in one RAM with clear, hill stamp and cell read commands.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low. Each item
// gives one result on height_value and saturated, shown for a single cycle
// with done high; the receiver cannot hold it off.
// Clear writes zero to every cell, one cell per cycle. A stamp walks the
// (2r-1) x (2r-1) square around its centre at one cell per cycle: the map
// RAM is read for one cell while the sum for the cell before is written
// back, as the map RAM has a single read and a single write port. busy is
// high from accept until done.
// After reset the block runs the same clearing pass (busy high) and then
// accepts items; this pass gives no result.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_hill_stamp #(
  parameter int MAP_SIDE    = 256,
  parameter int MAX_RADIUS  = 256,
  parameter int HEIGHT_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [hhs_pkg::CMD_W-1:0]       cmd,
  input  wire logic [hhs_pkg::COORD_W-1:0]     x_coord,
  input  wire logic [hhs_pkg::COORD_W-1:0]     y_coord,
  input  wire logic [hhs_pkg::RADIUS_W-1:0]    hill_radius,
  output logic                                 done,
  output logic      [hhs_pkg::RESULT_W-1:0]    height_value,
  output logic                                 saturated
);

  import hhs_pkg::*;

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAP_SIDE);
  // signed cell coordinate, wide enough for centre plus offset and MAP_SIDE
  localparam int CW    = ((SW > 9) ? SW : 9) + 2;
  localparam int RMAX_CLIP = (MAX_RADIUS > 255) ? 255 : MAX_RADIUS;
  localparam logic [RADIUS_W-1:0]    RMAX      = RADIUS_W'(RMAX_CLIP);
  localparam logic [CW-2:0]          SIDE      = (CW-1)'(MAP_SIDE);
  localparam logic [AW-1:0]          SIDE_A    = AW'(MAP_SIDE);
  localparam logic [AW-1:0]          LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [HEIGHT_BITS-1:0] CELL_MAX  = '1;

  state_t state, state_next;

  cmd_t                     cmd_r;
  logic [COORD_W-1:0]       cx;
  logic [COORD_W-1:0]       cy;
  logic [RADIUS_W-1:0]      rad;
  logic [SQ_W-1:0]          peak;
  logic [SQ_W-1:0]          edge_sq;
  logic signed [OFS_W-1:0]  dx;
  logic signed [OFS_W-1:0]  dy;
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_y;
  logic [AW-1:0]            clr_addr;
  logic                     user_clear;
  logic                     sat_flag;
  logic                     wr_pend;
  logic [AW-1:0]            wr_addr;
  logic [SQ_W-1:0]          wr_amt;

  // ram ports
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [HEIGHT_BITS-1:0]   ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [HEIGHT_BITS-1:0]   ram_rdata;

  logic                     accept;
  logic                     finish;
  logic [RADIUS_W-1:0]      r_eff;
  logic [RADIUS_W-1:0]      r_m1;
  logic signed [OFS_W-1:0]  r_top;
  logic                     col_end;
  logic                     row_end;
  logic signed [CW-1:0]     col;
  logic signed [CW-1:0]     row;
  logic                     in_map;
  logic [AW-1:0]            cell_addr;
  logic [DIST_W-1:0]        dist_sq;
  logic signed [AMT_W-1:0]  amount;
  logic                     hit;
  logic [HEIGHT_BITS:0]     sum;
  logic                     clip;
  logic [SQ_W-1:0]          sq_x_step;
  logic [SQ_W-1:0]          sq_y_step;

  hhs_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign r_eff  = (hill_radius > RMAX) ? RMAX : hill_radius;
  assign r_m1   = rad - 1'b1;
  assign r_top  = $signed({1'b0, r_m1});
  assign col_end = (dx == r_top);
  assign row_end = (dy == r_top);

  // current cell: stamp walks offsets, read uses the centre itself
  always_comb begin
    if (state == ST_STAMP) begin
      col = CW'($signed({1'b0, cx})) + CW'(dx);
      row = CW'($signed({1'b0, cy})) + CW'(dy);
    end else begin
      col = CW'($signed({1'b0, cx}));
      row = CW'($signed({1'b0, cy}));
    end
  end

  assign in_map = !col[CW-1] && !row[CW-1] && (col[CW-2:0] < SIDE) && (row[CW-2:0] < SIDE);
  assign cell_addr = AW'(row[SW-1:0]) * SIDE_A + AW'(col[SW-1:0]);

  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign amount  = $signed({2'b00, peak}) - $signed({1'b0, dist_sq});
  assign hit     = in_map && !amount[AMT_W-1] && (amount != '0);

  // (d+1)^2 = d^2 + 2d + 1
  assign sq_x_step = sq_x + SQ_W'($signed({dx, 1'b1}));
  assign sq_y_step = sq_y + SQ_W'($signed({dy, 1'b1}));

  // write-back half of the read-modify-write
  assign sum  = {1'b0, ram_rdata} + (HEIGHT_BITS+1)'(wr_amt);
  assign clip = sum[HEIGHT_BITS];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd_t'(cmd))
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_STAMP: state_next = ST_SETUP;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = user_clear ? ST_RESP : ST_IDLE;
        end
      end
      ST_SETUP: state_next = (rad == '0) ? ST_RESP : ST_STAMP;
      ST_STAMP: begin
        if (col_end && row_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_RESP;
      ST_READ:  state_next = ST_RESP;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = clip ? CELL_MAX : sum[HEIGHT_BITS-1:0];
    ram_re    = 1'b0;
    ram_raddr = cell_addr;
    finish    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_STAMP: begin
        ram_we = wr_pend;
        ram_re = hit;
      end
      ST_DRAIN: ram_we = wr_pend;
      ST_READ:  ram_re = 1'b1;
      ST_RESP:  finish = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      user_clear <= 1'b0;
      wr_pend    <= 1'b0;
      done       <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= finish;
      wr_pend <= (state == ST_STAMP) && hit;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        clr_addr   <= '0;
        user_clear <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_t'(cmd);
      cx       <= x_coord;
      cy       <= y_coord;
      rad      <= r_eff;
      sat_flag <= 1'b0;
    end
    if (state == ST_SETUP) begin
      peak    <= SQ_W'(rad) * SQ_W'(rad);
      edge_sq <= SQ_W'(r_m1) * SQ_W'(r_m1);
      sq_x    <= SQ_W'(r_m1) * SQ_W'(r_m1);
      sq_y    <= SQ_W'(r_m1) * SQ_W'(r_m1);
      dx      <= -r_top;
      dy      <= -r_top;
    end
    if (state == ST_STAMP) begin
      wr_addr <= cell_addr;
      wr_amt  <= amount[SQ_W-1:0];
      if (col_end) begin
        dx   <= -r_top;
        sq_x <= edge_sq;
        dy   <= dy + 1'b1;
        sq_y <= sq_y_step;
      end else begin
        dx   <= dx + 1'b1;
        sq_x <= sq_x_step;
      end
    end
    if (ram_we && wr_pend && clip && (state == ST_STAMP || state == ST_DRAIN)) begin
      sat_flag <= 1'b1;
    end
    if (finish) begin
      height_value <= ((cmd_r == CMD_READ) && in_map) ? RESULT_W'(ram_rdata) : '0;
      saturated    <= (cmd_r == CMD_STAMP) && sat_flag;
    end
  end

endmodule

`default_nettype wire
